// ===== rtl/serial_rate_command_parser_unit_defines.svh =====
// Assertion macros shared by the serial rate command parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SERIAL_RATE_COMMAND_PARSER_UNIT_DEFINES_SVH
`define SERIAL_RATE_COMMAND_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SRCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/srcp_pkg.sv =====
// Package for the serial rate command parser: job type, character codes,
// register indexes, reset values and keyword tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srcp_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE_DIVIDEND = 2'd0;
  localparam logic [1:0] REG_VALUE_LIMIT   = 2'd1;

  localparam logic [15:0] RATE_DIVIDEND_RST = 16'd50455;
  localparam logic [15:0] VALUE_LIMIT_RST   = 16'd5000;

  localparam int LINE_LENGTH_DEF = 100;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_LOW_Z = 8'd122;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // Target codes
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_RPM   = 2'd1;
  localparam logic [1:0] TGT_SPEED = 2'd2;

  localparam logic [16:0] MAG_MAX = 17'h1FFFF;

  // One parsed line handed from the front end to the divider
  typedef struct packed {
    logic [1:0]  target;  // TGT_NONE marks an incorrect message
    logic [15:0] value;   // already clamped to the limit
  } job_t;

  // Expected letter of "RPM" at a given name position
  function automatic logic [7:0] rpm_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'd82;  // R
      3'd1:    ch = 8'd80;  // P
      default: ch = 8'd77;  // M
    endcase
    return ch;
  endfunction

  // Expected letter of "SPEED" at a given name position
  function automatic logic [7:0] speed_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:      ch = 8'd83;  // S
      3'd1:      ch = 8'd80;  // P
      3'd2, 3'd3: ch = 8'd69; // E
      default:   ch = 8'd68;  // D
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srcp_front.sv =====
// Front end: takes one character per beat, tracks name match and value digits,
// emits one job per line end. Depends on srcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcp_front #(
  parameter int LINE_LENGTH = srcp_pkg::LINE_LENGTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic [15:0]    value_limit,
  output logic                job_valid,
  input  wire logic           job_ready,
  output srcp_pkg::job_t      job
);

  localparam int CW = $clog2(LINE_LENGTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(LINE_LENGTH - 1);

  localparam logic [1:0] PH_NAME    = 2'd0;
  localparam logic [1:0] PH_BLANKS  = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    len_r, len_nxt;
  logic          rpm_r, rpm_nxt;
  logic          speed_r, speed_nxt;
  logic [16:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic          ended_r, ended_nxt;

  logic        accept, line_end;
  logic [7:0]  ch;
  logic        is_blank, is_sign, is_digit, digit_step;
  logic [20:0] acc;
  logic        sep_seen;

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign line_end  = (in_rx_byte == srcp_pkg::CH_CR) || (in_rx_byte == srcp_pkg::CH_LF);
  assign job_valid = in_valid && line_end;

  // Fold lower case onto upper case
  always_comb begin
    if (in_rx_byte >= srcp_pkg::CH_LOW_A && in_rx_byte <= srcp_pkg::CH_LOW_Z) begin
      ch = in_rx_byte - srcp_pkg::CASE_OFS;
    end else begin
      ch = in_rx_byte;
    end
  end

  assign is_blank = (ch == srcp_pkg::CH_SPACE) || (ch == srcp_pkg::CH_TAB) ||
                    (ch == srcp_pkg::CH_VT) || (ch == srcp_pkg::CH_FF);
  assign is_sign  = (ch == srcp_pkg::CH_PLUS) || (ch == srcp_pkg::CH_MINUS);
  assign is_digit = (ch >= srcp_pkg::CH_ZERO) && (ch <= srcp_pkg::CH_NINE);
  assign digit_step = (phase_r == PH_DIGITS) ||
                      ((phase_r == PH_BLANKS) && !is_blank && !is_sign);

  // mag*10 + digit, saturated later
  assign acc = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {17'd0, ch[3:0]};

  // Job assembly at line end: classify name, clamp value
  assign sep_seen = (phase_r != PH_NAME);
  always_comb begin
    job.target = srcp_pkg::TGT_NONE;
    if (sep_seen && len_r == 3'd3 && rpm_r) begin
      job.target = srcp_pkg::TGT_RPM;
    end else if (sep_seen && len_r == 3'd5 && speed_r) begin
      job.target = srcp_pkg::TGT_SPEED;
    end
    if (neg_r && mag_r != 17'd0) begin
      job.value = value_limit;
    end else if (mag_r > {1'b0, value_limit}) begin
      job.value = value_limit;
    end else begin
      job.value = mag_r[15:0];
    end
  end

  // Line state update
  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    rpm_nxt   = rpm_r;
    speed_nxt = speed_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ended_nxt = ended_r;
    if (accept) begin
      if (line_end) begin
        count_nxt = '0;
        phase_nxt = PH_NAME;
        len_nxt   = 3'd0;
        rpm_nxt   = 1'b1;
        speed_nxt = 1'b1;
        mag_nxt   = 17'd0;
        neg_nxt   = 1'b0;
        ended_nxt = 1'b0;
      end else if (!ended_r && count_r < CNT_LAST) begin
        if (in_rx_byte == srcp_pkg::CH_NUL) begin
          ended_nxt = 1'b1;
        end else begin
          count_nxt = count_r + CW'(1);
          if (phase_r == PH_NAME) begin
            if (ch == srcp_pkg::CH_SEMI) begin
              phase_nxt = PH_BLANKS;
            end else begin
              if (len_r >= 3'd3 || ch != srcp_pkg::rpm_char(len_r)) rpm_nxt = 1'b0;
              if (len_r >= 3'd5 || ch != srcp_pkg::speed_char(len_r)) speed_nxt = 1'b0;
              if (len_r < 3'd7) len_nxt = len_r + 3'd1;
            end
          end else if (phase_r == PH_BLANKS && is_sign) begin
            neg_nxt   = (ch == srcp_pkg::CH_MINUS);
            phase_nxt = PH_DIGITS;
          end else if (digit_step) begin
            if (is_digit) begin
              phase_nxt = PH_DIGITS;
              mag_nxt   = (acc > {4'd0, srcp_pkg::MAG_MAX}) ? srcp_pkg::MAG_MAX : acc[16:0];
            end else begin
              phase_nxt = PH_STOPPED;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= PH_NAME;
      len_r   <= 3'd0;
      rpm_r   <= 1'b1;
      speed_r <= 1'b1;
      mag_r   <= 17'd0;
      neg_r   <= 1'b0;
      ended_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      rpm_r   <= rpm_nxt;
      speed_r <= speed_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      ended_r <= ended_nxt;
    end
  end

`include "serial_rate_command_parser_unit_defines.svh"

  `SRCP_ASSERT_NXT(a_line_clears, clk, rst_n, accept && line_end, count_r == '0 && phase_r == PH_NAME && !ended_r, "line state not cleared after line end")
  `SRCP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_LAST, "character count past line length")
  `SRCP_ASSERT_IMP(a_job_name, clk, rst_n, job_valid && job.target != srcp_pkg::TGT_NONE, phase_r != PH_NAME, "target chosen without separator")

endmodule

`default_nettype wire

// ===== rtl/srcp_queue.sv =====
// Two-entry job queue between the front end and the divider.
// Depends on srcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcp_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire srcp_pkg::job_t push_job,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output srcp_pkg::job_t pop_job
);

  srcp_pkg::job_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`include "serial_rate_command_parser_unit_defines.svh"

  `SRCP_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue count out of range")
  `SRCP_ASSERT_IMP(a_ptr_cnt, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r, "pointers disagree with count")
  `SRCP_ASSERT_NXT(a_push_only, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push did not raise count")

endmodule

`default_nettype wire

// ===== rtl/srcp_back.sv =====
// Back end: 16-step restoring divider forming dividend/value - 1 and the
// result output register. Depends on srcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcp_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  wire srcp_pkg::job_t job,
  input  wire logic [15:0] rate_dividend,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [1:0]       out_target,
  output logic [15:0]      out_prescaler
);

  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] div_r;
  logic [1:0]  tgt_r;
  logic        ovld_r, ovld_nxt;
  logic        status_r;
  logic [1:0]  target_r;
  logic [15:0] presc_r;

  logic        take, last, ge, load_out;
  logic [16:0] shifted;

  assign job_ready = !busy_r && !ovld_r;
  assign take      = job_valid && job_ready;
  assign last      = busy_r && (step_r == 4'd15);
  assign load_out  = last || (take && job.target == srcp_pkg::TGT_NONE);

  // One quotient bit per cycle
  assign shifted = {rem_r, quo_r[15]};
  assign ge      = (shifted >= {1'b0, div_r});
  assign rem_nxt = ge ? 16'(shifted - {1'b0, div_r}) : shifted[15:0];
  assign quo_nxt = {quo_r[14:0], ge};

  // Sequencing
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    ovld_nxt = ovld_r;
    if (out_valid && out_ready) ovld_nxt = 1'b0;
    if (take && job.target != srcp_pkg::TGT_NONE) begin
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 4'd1;
      if (last) busy_nxt = 1'b0;
    end
    if (load_out) ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      rem_r <= 16'd0;
      quo_r <= rate_dividend;
      div_r <= job.value;
      tgt_r <= job.target;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (take && job.target == srcp_pkg::TGT_NONE) begin
      status_r <= 1'b1;
      target_r <= srcp_pkg::TGT_NONE;
      presc_r  <= 16'd0;
    end else if (last) begin
      status_r <= 1'b0;
      target_r <= tgt_r;
      // a zero value counts as quotient zero
      presc_r  <= (div_r == 16'd0) ? 16'hFFFF : quo_nxt - 16'd1;
    end
  end

  assign out_valid     = ovld_r;
  assign out_status    = status_r;
  assign out_target    = target_r;
  assign out_prescaler = presc_r;

`include "serial_rate_command_parser_unit_defines.svh"

  `SRCP_ASSERT_IMP(a_not_both, clk, rst_n, busy_r, !ovld_r, "divider running while result held")
  `SRCP_ASSERT_NXT(a_div_start, clk, rst_n, take && job.target != srcp_pkg::TGT_NONE, busy_r && step_r == 4'd0, "division did not start")
  `SRCP_ASSERT_NXT(a_div_done, clk, rst_n, last, ovld_r && !out_status && out_target != srcp_pkg::TGT_NONE, "division end gave no result")
  `SRCP_ASSERT_IMP(a_bad_msg, clk, rst_n, out_valid && out_status, out_target == srcp_pkg::TGT_NONE && out_prescaler == 16'd0, "incorrect message with payload")

endmodule

`default_nettype wire

// ===== rtl/serial_rate_command_parser_unit.sv =====
// Top level of the serial rate command parser: configuration registers and
// front end, job queue and divider. Depends on srcp_pkg, srcp_front,
// srcp_queue, srcp_back.
//
//   Channel  Direction  Handshake        Payload
//   in_      input      valid / ready    rx_byte[7:0]
//   out_     output     valid / ready    status, target[1:0], prescaler[15:0]
//   cfg_     input      we, no wait      index[1:0], wdata[15:0]
//
// A character beat is taken whenever in_ready is high; in_ready drops only while the
// two-entry job queue is full. A command line end passes through the queue, then
// the 16 divider steps, the last of which loads the output register; an incorrect
// line loads the output register as soon as the divider takes it from the queue.
// The divider works one line at a time and sets the sustained line rate.
// Synchronous active-low reset clears line state, queue and result valid;
// registers reset to 50455 and 5000. A stalled output holds its beat while the
// front keeps parsing into the queue until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module serial_rate_command_parser_unit #(
  parameter int LINE_LENGTH = srcp_pkg::LINE_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [1:0]       out_target,
  output logic [15:0]      out_prescaler,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] rate_dividend_r;
  logic [15:0] value_limit_r;

  logic           fq_valid, fq_ready;
  srcp_pkg::job_t fq_job;
  logic           qb_valid, qb_ready;
  srcp_pkg::job_t qb_job;

  // Configuration registers; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_dividend_r <= srcp_pkg::RATE_DIVIDEND_RST;
      value_limit_r   <= srcp_pkg::VALUE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srcp_pkg::REG_RATE_DIVIDEND: rate_dividend_r <= cfg_wdata;
        srcp_pkg::REG_VALUE_LIMIT:   value_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  srcp_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .value_limit (value_limit_r),
    .job_valid   (fq_valid),
    .job_ready   (fq_ready),
    .job         (fq_job)
  );

  srcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  srcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (qb_valid),
    .job_ready     (qb_ready),
    .job           (qb_job),
    .rate_dividend (rate_dividend_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_target    (out_target),
    .out_prescaler (out_prescaler)
  );

endmodule

`default_nettype wire

// ===== bench/tb_serial_rate_command_parser_unit.sv =====
// Testbench for serial_rate_command_parser_unit: it streams text lines through the
// byte channel and checks every reply against a parser model kept in this file.
// Depends on srcp_pkg and the RTL of the parser unit.
`timescale 1ns / 1ps

module tb_serial_rate_command_parser_unit;

  localparam int LINE_LEN       = srcp_pkg::LINE_LENGTH_DEF;
  localparam int STALL_LIMIT    = 4000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 30;    // divider latency with margin
  localparam int PHASE_BYTES    = 260;

  typedef enum logic [1:0] {PH_NAME, PH_BLANKS, PH_DIGITS, PH_STOPPED} field_phase_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  target;
    logic [15:0] prescaler;
  } command_result_t;

  // DUT ports
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [1:0]  out_target;
  logic [15:0] out_prescaler;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = srcp_pkg::REG_RATE_DIVIDEND;
  logic [15:0] cfg_wdata = 16'd0;

  // Stimulus and scoreboard
  logic [7:0]      tx_bytes[$];
  command_result_t expected_commands[$];
  int              bytes_queued = 0;
  int              mismatch_count = 0;
  int              results_seen = 0;
  int              stall_cycles = 0;
  int              hold_left = 0;
  logic            hold_done = 1'b0;
  logic            no_gaps = 1'b0;

  // Parser model state
  logic [15:0]  dividend_reg = srcp_pkg::RATE_DIVIDEND_RST;
  logic [15:0]  limit_reg = srcp_pkg::VALUE_LIMIT_RST;
  int           line_chars = 0;
  field_phase_t phase = PH_NAME;
  logic [2:0]   name_len = 3'd0;
  logic         rpm_ok = 1'b1;
  logic         speed_ok = 1'b1;
  logic [16:0]  mag = 17'd0;
  logic         neg = 1'b0;
  logic         nul_seen = 1'b0;
  string        rpm_word = "RPM";
  string        speed_word = "SPEED";

  serial_rate_command_parser_unit #(
    .LINE_LENGTH(LINE_LEN)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_target   (out_target),
    .out_prescaler(out_prescaler),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the line parser by one received byte; a line end queues the reply
  task automatic parse_rx_byte(input logic [7:0] rx);
    logic [7:0]      ch;
    logic            feed;
    logic            sep;
    logic [1:0]      tgt;
    int unsigned     acc;
    int unsigned     quo;
    command_result_t res;
    if (rx != srcp_pkg::CH_CR && rx != srcp_pkg::CH_LF) begin
      if (!nul_seen && line_chars < LINE_LEN - 1) begin
        if (rx == srcp_pkg::CH_NUL) begin
          nul_seen = 1'b1;
        end else begin
          line_chars++;
          ch = rx;
          if (ch >= srcp_pkg::CH_LOW_A && ch <= srcp_pkg::CH_LOW_Z) begin
            ch = ch - srcp_pkg::CASE_OFS;
          end
          feed = 1'b0;
          if (phase == PH_NAME) begin
            if (ch == srcp_pkg::CH_SEMI) begin
              phase = PH_BLANKS;
            end else begin
              if (name_len >= 3 || ch != rpm_word[name_len]) rpm_ok = 1'b0;
              if (name_len >= 5 || ch != speed_word[name_len]) speed_ok = 1'b0;
              if (name_len < 7) name_len++;
            end
          end else if (phase == PH_BLANKS) begin
            if (!(ch == srcp_pkg::CH_SPACE || ch == srcp_pkg::CH_TAB ||
                  ch == srcp_pkg::CH_VT || ch == srcp_pkg::CH_FF)) begin
              if (ch == srcp_pkg::CH_PLUS || ch == srcp_pkg::CH_MINUS) begin
                neg = (ch == srcp_pkg::CH_MINUS);
                phase = PH_DIGITS;
              end else begin
                phase = PH_DIGITS;
                feed = 1'b1;
              end
            end
          end else if (phase == PH_DIGITS) begin
            feed = 1'b1;
          end
          // atol-style digit accumulation, saturating
          if (feed) begin
            if (ch >= srcp_pkg::CH_ZERO && ch <= srcp_pkg::CH_NINE) begin
              acc = mag * 10 + (ch - srcp_pkg::CH_ZERO);
              mag = (acc > srcp_pkg::MAG_MAX) ? srcp_pkg::MAG_MAX : acc[16:0];
            end else begin
              phase = PH_STOPPED;
            end
          end
        end
      end
    end else begin
      sep = (phase != PH_NAME);
      tgt = srcp_pkg::TGT_NONE;
      if (sep && name_len == 3 && rpm_ok) tgt = srcp_pkg::TGT_RPM;
      else if (sep && name_len == 5 && speed_ok) tgt = srcp_pkg::TGT_SPEED;
      if (tgt == srcp_pkg::TGT_NONE) begin
        res = '{status: 1'b1, target: srcp_pkg::TGT_NONE, prescaler: 16'd0};
      end else begin
        acc = mag;
        if (neg && acc != 0) acc = limit_reg;
        if (acc > limit_reg) acc = limit_reg;
        quo = (acc == 0) ? 0 : dividend_reg / acc;
        res = '{status: 1'b0, target: tgt, prescaler: 16'(quo - 1)};
      end
      expected_commands.push_back(res);
      line_chars = 0;
      phase = PH_NAME;
      name_len = 3'd0;
      rpm_ok = 1'b1;
      speed_ok = 1'b1;
      mag = 17'd0;
      neg = 1'b0;
      nul_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Keyword with random letter case
  task automatic push_word(input string s);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) ch = ch + srcp_pkg::CASE_OFS;
      push_byte(ch);
    end
  endtask

  task automatic push_blank();
    case ($urandom_range(0, 3))
      0:       push_byte(srcp_pkg::CH_SPACE);
      1:       push_byte(srcp_pkg::CH_TAB);
      2:       push_byte(srcp_pkg::CH_VT);
      default: push_byte(srcp_pkg::CH_FF);
    endcase
  endtask

  // One random line: mostly well-formed commands, some near misses and noise
  task automatic push_random_line();
    int kind;
    int ndig;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      if (kind < 50) push_word("RPM");
      else if (kind < 88) push_word("SPEED");
      else begin
        case ($urandom_range(0, 6))
          0:       push_word("RP");
          1:       push_word("RPMM");
          2:       push_word("SPEE");
          3:       push_word("SPEEDY");
          4:       push_word("RXM");
          5:       push_word("SPEEDS");
          default: ;  // empty name
        endcase
      end
      if ($urandom_range(0, 9) != 0) push_byte(srcp_pkg::CH_SEMI);
      if ($urandom_range(0, 49) == 0) begin
        // long line; the digits may fall past the kept length
        repeat ($urandom_range(80, 110)) push_byte(srcp_pkg::CH_SPACE);
      end else begin
        repeat ($urandom_range(0, 2)) push_blank();
      end
      case ($urandom_range(0, 5))
        0:       push_byte(srcp_pkg::CH_MINUS);
        1:       push_byte(srcp_pkg::CH_PLUS);
        default: ;
      endcase
      kind = $urandom_range(0, 99);
      ndig = (kind < 5) ? 0 : (kind < 90) ? $urandom_range(1, 5) : $urandom_range(6, 8);
      repeat (ndig) push_byte(srcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      case ($urandom_range(0, 19))
        0:       push_text("x7");
        1:       begin push_byte(srcp_pkg::CH_NUL); push_text("99"); end
        2:       push_byte(8'($urandom_range(128, 255)));
        default: ;
      endcase
    end
    push_byte($urandom_range(0, 1) ? srcp_pkg::CH_CR : srcp_pkg::CH_LF);
  endtask

  task automatic push_random_lines(input int nbytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < nbytes) push_random_line();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srcp_pkg::REG_RATE_DIVIDEND) dividend_reg = data;
    else if (idx == srcp_pkg::REG_VALUE_LIMIT) limit_reg = data;
  endtask

  // Wait for all replies, then let the divider settle
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || expected_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'd0;
    end else begin
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 23)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off once replies are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_left = HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 23);
    end
  end

  // Reply monitor
  always @(posedge clk) begin
    command_result_t exp_cmd;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_commands.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: st=%0d tgt=%0d psc=%0d",
                                  out_status, out_target, out_prescaler));
      end else begin
        exp_cmd = expected_commands.pop_front();
        if (out_status !== exp_cmd.status)
          report_mismatch($sformatf("out_status got %0d want %0d", out_status, exp_cmd.status));
        if (out_target !== exp_cmd.target)
          report_mismatch($sformatf("out_target got %0d want %0d", out_target, exp_cmd.target));
        if (out_prescaler !== exp_cmd.prescaler)
          report_mismatch($sformatf("out_prescaler got %0d want %0d",
                                    out_prescaler, exp_cmd.prescaler));
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    logic [15:0] dividends[6];
    logic [15:0] limits[6];
    dividends = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd0, 16'd0};
    limits    = '{16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at reset register values
    push_text("RPM;100\r");
    push_text("speed;250\n");
    push_text("\r");                       // empty line
    push_text("RPM\r");                    // no separator
    push_text("Rpmx;10\r");                // name too long
    push_text(";5\r");                     // empty name
    push_text("SPEED;");                   // all blank kinds, then a negative value
    push_byte(srcp_pkg::CH_SPACE); push_byte(srcp_pkg::CH_TAB);
    push_byte(srcp_pkg::CH_VT); push_byte(srcp_pkg::CH_FF);
    push_text("-7\r");
    push_text("RPM;-0\r");                 // minus zero stays zero
    push_text("rpm;0\r");                  // zero value
    push_text("SPEED;+99999999\r");        // saturating magnitude
    push_text("RPM;12ab\r");               // digits stop at a letter
    push_text("SPEED;  +\r");              // sign without digits
    push_text("RPM;60000\r");              // above the limit
    push_text("RPM;;5\n");                 // second separator stops the value
    push_text("SPEED;12");                 // NUL ends the text
    push_byte(srcp_pkg::CH_NUL);
    push_text("34\r");
    push_byte(8'hFF);                      // high byte in the name
    push_text("PM;1\r");
    push_text("RPM;");                     // only the first LINE_LEN-1 chars count
    repeat (LINE_LEN - 6) push_byte(srcp_pkg::CH_SPACE);
    push_text("1234\r");
    wait_idle();

    // Random phases across register settings, extremes first
    for (int p = 0; p < 6; p++) begin
      write_reg(srcp_pkg::REG_RATE_DIVIDEND,
                (p < 4) ? dividends[p] : 16'($urandom_range(1, 65535)));
      write_reg(srcp_pkg::REG_VALUE_LIMIT,
                (p < 4) ? limits[p] : 16'($urandom_range(1, 65535)));
      no_gaps = (p == 2);
      push_random_lines(PHASE_BYTES);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srcp_pkg.sv
rtl/srcp_front.sv
rtl/srcp_queue.sv
rtl/srcp_back.sv
rtl/serial_rate_command_parser_unit.sv
bench/tb_serial_rate_command_parser_unit.sv
